// File: src/syscall_event_histogram_top_defines.svh
// Assertion macros of the histogram RTL.
// Included by syh_dp, the only file that carries concurrent checks; no other dependencies.
`ifndef SYSCALL_EVENT_HISTOGRAM_TOP_DEFINES_SVH
`define SYSCALL_EVENT_HISTOGRAM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SYH_ASSERT_IMPLIES(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("syh: assertion failed");
`define SYH_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("syh: assertion failed");
`else
`define SYH_ASSERT_IMPLIES(label, ck, rn, ante, cons)
`define SYH_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

// File: src/syh_pkg.sv
// Types and fixed codes of the system-call event histogram.
// Used by the controller, the datapath and the top level; no dependencies.
package syh_pkg;

  // Request commands.
  localparam logic [1:0] CMD_EVENT    = 2'd0;
  localparam logic [1:0] CMD_RD_DENSE = 2'd1;
  localparam logic [1:0] CMD_RD_OVF   = 2'd2;
  localparam logic [1:0] CMD_RD_LOST  = 2'd3;

  // Result outcomes.
  localparam logic [2:0] OUT_IGNORED = 3'd0;
  localparam logic [2:0] OUT_DENSE   = 3'd1;
  localparam logic [2:0] OUT_OVF     = 3'd2;
  localparam logic [2:0] OUT_LOST    = 3'd3;
  localparam logic [2:0] OUT_HIT     = 3'd4;
  localparam logic [2:0] OUT_MISS    = 3'd5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_NS      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_TICKS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PID   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARCH_MODE    = 8'd3;

  // Calling conventions and flag bits.
  localparam logic [1:0] ABI_NATIVE = 2'd0;
  localparam logic [1:0] ABI_COMPAT = 2'd1;
  localparam logic [1:0] ABI_X32    = 2'd2;
  localparam int X32_BIT_POS      = 30;
  localparam int TS_COMPAT_POS    = 1;
  localparam int TIF_32BIT_POS    = 22;

  // Restoring divider, one quotient bit per cycle.
  localparam int DIV_CNT_W = 7;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'd64;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] tgid;
    logic        ns_fail;
    logic [31:0] ns_tgid;
    logic        start_read_fail;
    logic [63:0] start_time;
    logic        flags_read_fail;
    logic [31:0] thread_flags;
    logic [63:0] number;
    logic [1:0]  read_abi;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [63:0] count_value;
  } out_item_t;

  // One overflow table row.
  typedef struct packed {
    logic [63:0] count;
    logic [1:0]  abi;
    logic [63:0] num;
  } ovf_row_t;

  typedef enum logic [2:0] {
    VAL_ZERO, VAL_DENSE_INC, VAL_DENSE_RD, VAL_OVF_INC,
    VAL_OVF_RD, VAL_ONE, VAL_LOST_NEXT, VAL_LOST
  } val_src_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_DIV, S_CHECK, S_DRD, S_DUPD,
    S_SCAN, S_SCMP, S_OHIT
  } ctl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;
    logic       clr_step;
    logic       div_start;
    logic       div_step;
    logic       pin;
    logic       dense_rd;
    logic       dense_wr;
    logic       scan_start;
    logic       scan_rd;
    logic       scan_step;
    logic       ovf_upd;
    logic       ovf_ins;
    logic       lost_inc;
    logic       res_load;
    logic [2:0] res_code;
    val_src_t   res_src;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] command;
    logic       pre_ignore;
    logic       div_done;
    logic       quot_match;
    logic       flags_fail;
    logic       abi_bad;
    logic       dense_ok;
    logic       dense_sat;
    logic       scan_end;
    logic       scan_hit;
    logic       table_full;
    logic       ovf_sat;
    logic       clr_done;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: src/syh_ctrl.sv
// Controller state machine of the histogram.
// Depends on syh_pkg; drives the datapath through ctl_cmd_t.
module syh_ctrl import syh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.res_src = VAL_ZERO;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.out_free) begin
          case (stat.command)
            CMD_EVENT: begin
              if (stat.pre_ignore) begin
                cmd.res_load = 1'b1;
                cmd.res_code = OUT_IGNORED;
                state_nxt = S_IDLE;
              end else begin
                cmd.div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            CMD_RD_DENSE: begin
              if (stat.dense_ok) begin
                cmd.dense_rd = 1'b1;
                state_nxt = S_DRD;
              end else begin
                cmd.res_load = 1'b1;
                cmd.res_code = OUT_MISS;
                state_nxt = S_IDLE;
              end
            end
            CMD_RD_OVF: begin
              cmd.scan_start = 1'b1;
              state_nxt = S_SCAN;
            end
            default: begin
              cmd.res_load = 1'b1;
              cmd.res_code = OUT_HIT;
              cmd.res_src = VAL_LOST;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      // Start-time check passed or not; then pin and pick the counter.
      S_CHECK: begin
        if (stat.out_free) begin
          if (!stat.quot_match) begin
            cmd.res_load = 1'b1;
            cmd.res_code = OUT_IGNORED;
            state_nxt = S_IDLE;
          end else begin
            cmd.pin = 1'b1;
            if (stat.flags_fail || stat.abi_bad) begin
              cmd.lost_inc = 1'b1;
              cmd.res_load = 1'b1;
              cmd.res_code = OUT_LOST;
              cmd.res_src = VAL_LOST_NEXT;
              state_nxt = S_IDLE;
            end else if (stat.dense_ok) begin
              cmd.dense_rd = 1'b1;
              state_nxt = S_DRD;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_DRD: begin
        state_nxt = S_DUPD;
      end
      S_DUPD: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt = S_IDLE;
          if (stat.command == CMD_RD_DENSE) begin
            cmd.res_code = OUT_HIT;
            cmd.res_src = VAL_DENSE_RD;
          end else if (stat.dense_sat) begin
            cmd.lost_inc = 1'b1;
            cmd.res_code = OUT_LOST;
            cmd.res_src = VAL_LOST_NEXT;
          end else begin
            cmd.dense_wr = 1'b1;
            cmd.res_code = OUT_DENSE;
            cmd.res_src = VAL_DENSE_INC;
          end
        end
      end
      // Walk the filled part of the overflow table.
      S_SCAN: begin
        if (!stat.scan_end) begin
          cmd.scan_rd = 1'b1;
          state_nxt = S_SCMP;
        end else if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt = S_IDLE;
          if (stat.command == CMD_RD_OVF) begin
            cmd.res_code = OUT_MISS;
          end else if (stat.table_full) begin
            cmd.lost_inc = 1'b1;
            cmd.res_code = OUT_LOST;
            cmd.res_src = VAL_LOST_NEXT;
          end else begin
            cmd.ovf_ins = 1'b1;
            cmd.res_code = OUT_OVF;
            cmd.res_src = VAL_ONE;
          end
        end
      end
      S_SCMP: begin
        if (stat.scan_hit) begin
          state_nxt = S_OHIT;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_OHIT: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt = S_IDLE;
          if (stat.command == CMD_RD_OVF) begin
            cmd.res_code = OUT_HIT;
            cmd.res_src = VAL_OVF_RD;
          end else if (stat.ovf_sat) begin
            cmd.lost_inc = 1'b1;
            cmd.res_code = OUT_LOST;
            cmd.res_src = VAL_LOST_NEXT;
          end else begin
            cmd.ovf_upd = 1'b1;
            cmd.res_code = OUT_OVF;
            cmd.res_src = VAL_OVF_INC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/syh_dp.sv
// Datapath of the histogram: configuration, divider, counter memories, result register.
// Depends on syh_pkg and the assertion macros header.
`include "syscall_event_histogram_top_defines.svh"
module syh_dp import syh_pkg::*; #(
  parameter int DENSE_SLOTS      = 1024,
  parameter int ABI_COUNT        = 3,
  parameter int OVERFLOW_ENTRIES = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_item,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 out_ready,
  input  ctl_cmd_t             cmd,
  output dp_stat_t             stat,
  output logic                 out_valid,
  output out_item_t            out_item
);

  localparam int DENSE_TOTAL = ABI_COUNT * DENSE_SLOTS;
  localparam int DADDR_W     = $clog2(DENSE_TOTAL);
  localparam int OVF_W       = $clog2(OVERFLOW_ENTRIES);
  localparam int FILL_W      = OVF_W + 1;

  logic [63:0] tick_ns_r, leader_ticks_r;
  logic [31:0] target_pid_r, pinned_r;
  logic        arch_mode_r;
  in_item_t    item_r;
  logic [63:0] lost_r, lost_nxt;
  logic [FILL_W-1:0] fill_r, scan_idx_r;
  logic [DADDR_W-1:0] clr_cnt_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [63:0] rem_r, rem_nxt, dvd_r, dvd_nxt;
  logic [64:0] rem_sh;
  logic [64:0] rem_diff;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic [63:0] dense_q_r;
  ovf_row_t    row_r;
  logic [63:0] dense_mem [DENSE_TOTAL];
  ovf_row_t    ovf_mem [OVERFLOW_ENTRIES];

  logic [1:0]  ev_abi, key_abi;
  logic [63:0] key_index;
  logic [DADDR_W-1:0] dense_addr, dense_waddr;
  logic [63:0] dense_wdata;
  logic        dense_we;
  logic        out_free;
  logic [63:0] res_value;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_ns_r      <= '0;
      leader_ticks_r <= '0;
      target_pid_r   <= '0;
      arch_mode_r    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TICK_NS:      tick_ns_r <= cfg_data;
        CFG_LEADER_TICKS: leader_ticks_r <= cfg_data;
        CFG_TARGET_PID:   target_pid_r <= cfg_data[31:0];
        CFG_ARCH_MODE:    arch_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
  end

  // Calling convention and counter key of the held request.
  always_comb begin
    ev_abi = ABI_NATIVE;
    if (!arch_mode_r) begin
      if (item_r.thread_flags[TS_COMPAT_POS]) begin
        ev_abi = ABI_COMPAT;
      end else if (item_r.number[X32_BIT_POS]) begin
        ev_abi = ABI_X32;
      end
    end else if (item_r.thread_flags[TIF_32BIT_POS]) begin
      ev_abi = ABI_COMPAT;
    end
    key_abi = (item_r.command == CMD_EVENT) ? ev_abi : item_r.read_abi;
    key_index = item_r.number;
    if (key_abi == ABI_X32) begin
      key_index[X32_BIT_POS] = 1'b0;
    end
    dense_addr = DADDR_W'(key_abi) * DADDR_W'(DENSE_SLOTS)
               + DADDR_W'(key_index[DADDR_W-1:0]);
  end

  // Restoring divider: start_time / tick_ns, one bit per cycle.
  always_comb begin
    rem_sh   = {rem_r, dvd_r[63]};
    rem_diff = rem_sh - {1'b0, tick_ns_r};
    if (!rem_diff[64]) begin
      rem_nxt = rem_diff[63:0];
      dvd_nxt = {dvd_r[62:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[63:0];
      dvd_nxt = {dvd_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r     <= '0;
      dvd_r     <= item_r.start_time;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      dvd_r     <= dvd_nxt;
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // Pinned process, lost counter, table fill and clearing sweep.
  assign lost_nxt = (lost_r == '1) ? lost_r : lost_r + 64'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pinned_r   <= '0;
      lost_r     <= '0;
      fill_r     <= '0;
      clr_cnt_r  <= '0;
      scan_idx_r <= '0;
    end else begin
      if (cmd.pin) begin
        pinned_r <= item_r.tgid;
      end
      if (cmd.lost_inc) begin
        lost_r <= lost_nxt;
      end
      if (cmd.ovf_ins) begin
        fill_r <= fill_r + FILL_W'(1);
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + DADDR_W'(1);
      end
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_step) begin
        scan_idx_r <= scan_idx_r + FILL_W'(1);
      end
    end
  end

  // Dense counter memory: one write port, one registered read port.
  assign dense_we    = cmd.clr_step || cmd.dense_wr;
  assign dense_waddr = cmd.clr_step ? clr_cnt_r : dense_addr;
  assign dense_wdata = cmd.clr_step ? 64'd0 : dense_q_r + 64'd1;

  always_ff @(posedge clk) begin
    if (dense_we) begin
      dense_mem[dense_waddr] <= dense_wdata;
    end
    if (cmd.dense_rd) begin
      dense_q_r <= dense_mem[dense_addr];
    end
  end

  // Overflow table memory: rows below the fill count are valid.
  always_ff @(posedge clk) begin
    if (cmd.ovf_ins) begin
      ovf_mem[fill_r[OVF_W-1:0]] <= '{count: 64'd1, abi: key_abi, num: item_r.number};
    end else if (cmd.ovf_upd) begin
      ovf_mem[scan_idx_r[OVF_W-1:0]] <= '{count: row_r.count + 64'd1, abi: row_r.abi,
                                          num: row_r.num};
    end
    if (cmd.scan_rd) begin
      row_r <= ovf_mem[scan_idx_r[OVF_W-1:0]];
    end
  end

  // Status toward the controller.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat.command    = item_r.command;
    stat.pre_ignore = (pinned_r != '0 && pinned_r != item_r.tgid) || (tick_ns_r == '0)
                    || (pinned_r == '0 && (item_r.ns_fail || item_r.ns_tgid != target_pid_r))
                    || item_r.start_read_fail;
    stat.div_done   = (div_cnt_r == DIV_STEPS);
    stat.quot_match = (dvd_r == leader_ticks_r);
    stat.flags_fail = item_r.flags_read_fail;
    stat.abi_bad    = ({1'b0, ev_abi} >= 3'(ABI_COUNT));
    stat.dense_ok   = ({1'b0, key_abi} < 3'(ABI_COUNT)) && (key_index < 64'(DENSE_SLOTS));
    stat.dense_sat  = (dense_q_r == '1);
    stat.scan_end   = (scan_idx_r == fill_r);
    stat.scan_hit   = (row_r.num == item_r.number) && (row_r.abi == key_abi);
    stat.table_full = (fill_r == FILL_W'(OVERFLOW_ENTRIES));
    stat.ovf_sat    = (row_r.count == '1);
    stat.clr_done   = (clr_cnt_r == DADDR_W'(DENSE_TOTAL - 1));
    stat.out_free   = out_free;
  end

  // Result register.
  always_comb begin
    case (cmd.res_src)
      VAL_ZERO:      res_value = 64'd0;
      VAL_DENSE_INC: res_value = dense_q_r + 64'd1;
      VAL_DENSE_RD:  res_value = dense_q_r;
      VAL_OVF_INC:   res_value = row_r.count + 64'd1;
      VAL_OVF_RD:    res_value = row_r.count;
      VAL_ONE:       res_value = 64'd1;
      VAL_LOST_NEXT: res_value = lost_nxt;
      VAL_LOST:      res_value = lost_r;
      default:       res_value = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_item_r <= '{outcome: cmd.res_code, count_value: res_value};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A new result never overwrites one still waiting.
  `SYH_ASSERT_IMPLIES(a_res_free, clk, rst_n, cmd.res_load, out_free)
  // Nothing is inserted into a full table.
  `SYH_ASSERT_IMPLIES(a_ins_room, clk, rst_n, cmd.ovf_ins, fill_r < FILL_W'(OVERFLOW_ENTRIES))
  // Table reads stay within the filled rows.
  `SYH_ASSERT_IMPLIES(a_scan_bound, clk, rst_n, cmd.scan_rd, scan_idx_r < fill_r)
  // Each insertion grows the fill count by exactly one.
  `SYH_ASSERT_NEXT(a_fill_grow, clk, rst_n, cmd.ovf_ins, fill_r == $past(fill_r) + FILL_W'(1))

endmodule

// File: src/syscall_event_histogram_top.sv
// Top level of the system-call event histogram.
// Depends on syh_pkg, syh_ctrl and syh_dp.
//
// After reset the block clears all ABI_COUNT*DENSE_SLOTS words of the dense
// counter memory before it takes the first request; configuration writes are
// taken at any time. Requests are handled one at a time. A lost read, a dense
// read that misses, or an event rejected by the checks made before the
// division posts its result from the decode state. An event that passes them
// goes through the 64-step restoring divider that checks the start time and
// then the check state, which ignores it when the start time does not match.
// A matching event then reads and updates a dense counter, or compares the
// overflow table entries (the table memory delivers one row per read) and
// updates or inserts a row. A dense read that hits reads its counter; an
// overflow read compares the table entries. A finished result sits in the
// output register while the next request is taken; a request that is ready
// to post its result waits while the previous result has not been accepted.
module syscall_event_histogram_top import syh_pkg::*; #(
  parameter int DENSE_SLOTS      = 1024,
  parameter int ABI_COUNT        = 3,
  parameter int OVERFLOW_ENTRIES = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  syh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  syh_dp #(
    .DENSE_SLOTS      (DENSE_SLOTS),
    .ABI_COUNT        (ABI_COUNT),
    .OVERFLOW_ENTRIES (OVERFLOW_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
